// ===== rtl/core/srdd_pkg.sv =====
// ----------------------------------------------------------------------------
// srdd_pkg
// Shared types and constants of the lidar response deframer and decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srdd_pkg;

    // sizing
    localparam int MAX_STEPS  = 2048;
    localparam int ECHO_MAX   = 16;
    localparam int ECHO_LEN_W = $clog2(ECHO_MAX + 1);
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    // data character count, saturating at 2^24-1
    localparam int CNT_W      = 24;
    localparam int ACC_W      = 36;
    localparam int CHAR_BITS  = 6;
    localparam int TS_CHARS   = 4;

    // character codes
    localparam logic [7:0]  LF_CHAR         = 8'h0A;
    localparam logic [7:0]  DIGIT_BASE      = 8'h30;
    localparam logic [7:0]  STATUS_OK_CHAR  = 8'h30;
    localparam logic [7:0]  STATUS_ALT_CHAR = 8'h39;
    localparam logic [17:0] MIN_RANGE_MM    = 18'd20;

    // register indexes
    localparam logic [2:0] CFG_ECHO_LOW   = 3'd0;
    localparam logic [2:0] CFG_ECHO_HIGH  = 3'd1;
    localparam logic [2:0] CFG_ECHO_LEN   = 3'd2;
    localparam logic [2:0] CFG_RANGE_CNT  = 3'd3;
    localparam logic [2:0] CFG_INTENS_EN  = 3'd4;
    localparam logic [2:0] CFG_MAX_RANGE  = 3'd5;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_STATUS1,
        PH_STATUS2,
        PH_SUM,
        PH_HDRLF,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TIMESTAMP,
        KIND_RANGE,
        KIND_FRAME_END
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_STATUS,
        ST_LENGTH,
        ST_NO_LF
    } status_t;

    typedef struct packed {
        logic [63:0] echo_low_bytes;
        logic [63:0] echo_high_bytes;
        logic [4:0]  echo_length;
        logic [11:0] range_count;
        logic        intensity_enable;
        logic [17:0] max_range_mm;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } echo_ctrl_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] step_index;
        logic [23:0] value;
        logic [17:0] intensity;
        logic        range_valid;
        status_t     status;
    } result_t;

endpackage

// ===== rtl/core/scip_response_deframer_decoder.sv =====
// ----------------------------------------------------------------------------
// scip_response_deframer_decoder
// A byte taken is held in the input register and decoded from there; its
// result is registered in the result register and valid at the output from
// then on. Throughput: one byte per cycle unless out_stall holds a result.
// A result held by out_stall keeps the next byte in the input register.
// Reset: phase returns to echo hunt, frame counters clear, registers take
// their reset values; no clearing pass, bytes are taken straight after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scip_response_deframer_decoder
    import srdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [10:0] step_index,
    output logic [23:0] value,
    output logic [17:0] intensity,
    output logic        range_valid,
    output logic [1:0]  status
);

    cfg_t       cfg;
    echo_ctrl_t echo_ctrl;
    logic       echo_hit;
    logic       dec_valid;
    result_t    dec_res;

    logic       in_full_reg, in_full_next;
    logic [7:0] in_byte_reg;
    logic       out_full_reg, out_full_next;
    result_t    res_reg;
    logic       advance;
    logic       proc;
    logic       load;

    // handshake control
    assign advance       = !out_full_reg || !out_stall;
    assign proc          = in_full_reg && advance;
    assign in_stall      = in_full_reg && !advance;
    assign load          = in_valid && !in_stall;
    assign in_full_next  = load ? 1'b1 : (proc ? 1'b0 : in_full_reg);
    assign out_full_next = advance ? (proc && dec_valid) : out_full_reg;

    srdd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srdd_echo_match u_echo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .rx_char (in_byte_reg),
        .ctrl    (echo_ctrl),
        .hit     (echo_hit)
    );

    srdd_frame_decoder u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (proc),
        .rx_char   (in_byte_reg),
        .cfg       (cfg),
        .echo_hit  (echo_hit),
        .echo_ctrl (echo_ctrl),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= rx_byte;
        end
        if (proc && dec_valid)
        begin
            res_reg <= dec_res;
        end
    end

    assign out_valid   = out_full_reg;
    assign kind        = res_reg.kind;
    assign step_index  = res_reg.step_index;
    assign value       = res_reg.value;
    assign intensity   = res_reg.intensity;
    assign range_valid = res_reg.range_valid;
    assign status      = res_reg.status;

    // a byte waiting on a full result register is kept
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg && $stable(in_byte_reg))
        else $error("held input byte lost");

    // a status code only travels with a frame end
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && res_reg.kind != KIND_FRAME_END |-> res_reg.status == ST_OK)
        else $error("status on a non frame end transfer");

    // the valid range flag only travels with a range sample
    a_valid_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && res_reg.range_valid |-> res_reg.kind == KIND_RANGE)
        else $error("range flag on a non range transfer");

endmodule

// ===== rtl/core/srdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// srdd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdd_cfg_regs
    import srdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ECHO_LOW:  cfg_next.echo_low_bytes   = cfg_data;
                CFG_ECHO_HIGH: cfg_next.echo_high_bytes  = cfg_data;
                CFG_ECHO_LEN:  cfg_next.echo_length      = cfg_data[4:0];
                CFG_RANGE_CNT: cfg_next.range_count      = cfg_data[11:0];
                CFG_INTENS_EN: cfg_next.intensity_enable = cfg_data[0];
                CFG_MAX_RANGE: cfg_next.max_range_mm     = cfg_data[17:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.echo_low_bytes   <= '0;
            cfg_reg.echo_high_bytes  <= '0;
            cfg_reg.echo_length      <= '0;
            cfg_reg.range_count      <= 12'd1;
            cfg_reg.intensity_enable <= 1'b0;
            cfg_reg.max_range_mm     <= 18'd5600;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/srdd_echo_match.sv =====
// ----------------------------------------------------------------------------
// srdd_echo_match
// Sliding window over the received bytes and command echo comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdd_echo_match
    import srdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic [7:0] rx_char,
    input  echo_ctrl_t ctrl,
    output logic       hit
);

    logic [7:0]            window_reg [ECHO_MAX];
    logic [7:0]            window_next [ECHO_MAX];
    logic [ECHO_LEN_W-1:0] fill_reg;
    logic [ECHO_LEN_W-1:0] fill_next;
    logic [ECHO_LEN_W-1:0] len_eff;
    logic [127:0]          echo_bytes;
    logic [ECHO_MAX:0]     match_vec;

    assign echo_bytes = {cfg.echo_high_bytes, cfg.echo_low_bytes};

    // window after shifting in the new byte
    always_comb
    begin
        window_next[0] = rx_char;
        for (int i = 1; i < ECHO_MAX; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // saturating fill count and clamped echo length
    assign fill_next = (fill_reg == ECHO_LEN_W'(ECHO_MAX)) ? fill_reg
                                                           : fill_reg + 1'b1;
    assign len_eff   = (32'(cfg.echo_length) > ECHO_MAX) ? ECHO_LEN_W'(ECHO_MAX)
                                                         : cfg.echo_length[ECHO_LEN_W-1:0];

    // one comparison per possible echo length
    always_comb
    begin
        match_vec[0] = 1'b1;
        for (int l = 1; l <= ECHO_MAX; l++)
        begin
            match_vec[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (window_next[l-1-k] != echo_bytes[8*k +: 8])
                begin
                    match_vec[l] = 1'b0;
                end
            end
        end
    end

    assign hit = (fill_next >= len_eff) && match_vec[len_eff];

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            fill_reg <= fill_next;
        end
    end

    // window bytes, only read once the fill count covers them
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            window_reg <= window_next;
        end
    end

endmodule

// ===== rtl/core/srdd_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// srdd_frame_decoder
// Frame phase sequencer, data line stripping and field decoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdd_frame_decoder
    import srdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] rx_char,
    input  cfg_t       cfg,
    input  logic       echo_hit,
    output echo_ctrl_t echo_ctrl,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [CNT_W-1:0] CNT_CAP = '1;

    phase_t            phase_reg, phase_next;
    logic [7:0]        pend_char_reg, pend_char_next;
    logic              pend_flag_reg, pend_flag_next;
    logic              prev_lf_reg, prev_lf_next;
    logic [7:0]        status_first_reg, status_first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        mod6_reg, mod6_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [7:0]           diff;
    logic [ACC_W-1:0]     acc_sh;
    logic [STEP_W-1:0]    eff_ranges;
    logic [CNT_W-1:0]     eff_x3;
    logic [CNT_W-1:0]     expected;
    logic                 boundary;
    logic [17:0]          range_val;
    logic [17:0]          intens;
    logic                 is_lf;
    logic                 status_good;
    status_t              end_status;

    // field arithmetic on the pending character
    assign diff      = pend_char_reg - DIGIT_BASE;
    assign acc_sh    = {acc_reg[ACC_W-CHAR_BITS-1:0], diff[CHAR_BITS-1:0]};
    assign range_val = cfg.intensity_enable ? acc_sh[35:18] : acc_sh[17:0];
    assign intens    = cfg.intensity_enable ? acc_sh[17:0] : 18'd0;
    // a saturated count lands on a step boundary with every character
    assign boundary  = (count_reg == CNT_CAP)
                       || (cfg.intensity_enable ? (mod6_reg == 3'd5)
                                                : (mod6_reg == 3'd2 || mod6_reg == 3'd5));
    assign is_lf     = (rx_char == LF_CHAR);

    // expected character count and frame end status
    assign eff_ranges  = (32'(cfg.range_count) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                            : STEP_W'(cfg.range_count);
    assign eff_x3      = (CNT_W'(eff_ranges) << 1) + CNT_W'(eff_ranges);
    assign expected    = (cfg.intensity_enable ? (eff_x3 << 1) : eff_x3)
                         + CNT_W'(TS_CHARS);
    assign status_good = (status_first_reg == STATUS_OK_CHAR)
                         || (status_first_reg == STATUS_ALT_CHAR);
    assign end_status  = !status_good ? ST_BAD_STATUS
                       : (count_reg != expected) ? ST_LENGTH : ST_OK;

    // phase sequencer and result
    always_comb
    begin
        phase_next        = phase_reg;
        pend_char_next    = pend_char_reg;
        pend_flag_next    = pend_flag_reg;
        prev_lf_next      = prev_lf_reg;
        status_first_next = status_first_reg;
        count_next        = count_reg;
        mod6_next         = mod6_reg;
        acc_next          = acc_reg;
        step_next         = step_reg;
        echo_ctrl         = '0;
        res_valid         = 1'b0;
        res               = '0;

        if (en)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (cfg.echo_length == 5'd0 || echo_hit)
                    begin
                        pend_char_next    = '0;
                        pend_flag_next    = 1'b0;
                        prev_lf_next      = 1'b0;
                        status_first_next = '0;
                        count_next        = '0;
                        mod6_next         = '0;
                        acc_next          = '0;
                        step_next         = '0;
                        phase_next        = PH_STATUS1;
                    end
                    if (cfg.echo_length == 5'd0)
                    begin
                        // no echo: this byte is already the first status char
                        status_first_next = rx_char;
                        phase_next        = PH_STATUS2;
                    end
                    else
                    begin
                        echo_ctrl.shift = 1'b1;
                    end
                end
                PH_STATUS1:
                begin
                    status_first_next = rx_char;
                    phase_next        = PH_STATUS2;
                end
                PH_STATUS2:
                begin
                    phase_next = is_lf ? PH_HDRLF : PH_SUM;
                end
                PH_SUM:
                begin
                    phase_next = PH_HDRLF;
                end
                PH_HDRLF:
                begin
                    if (!is_lf)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_FRAME_END;
                        res.status      = ST_NO_LF;
                        echo_ctrl.clear = 1'b1;
                        phase_next      = PH_HUNT;
                    end
                    else
                    begin
                        prev_lf_next = 1'b1;
                        phase_next   = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (is_lf)
                    begin
                        if (prev_lf_reg)
                        begin
                            // blank line ends the frame
                            res_valid       = 1'b1;
                            res.kind        = KIND_FRAME_END;
                            res.status      = end_status;
                            echo_ctrl.clear = 1'b1;
                            phase_next      = PH_HUNT;
                        end
                        else
                        begin
                            // drop the sum character held back
                            pend_flag_next = 1'b0;
                            prev_lf_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pend_flag_reg)
                        begin
                            if (count_reg != CNT_CAP)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            if (count_reg < CNT_W'(TS_CHARS))
                            begin
                                if (count_reg == CNT_W'(TS_CHARS - 1))
                                begin
                                    res_valid = 1'b1;
                                    res.kind  = KIND_TIMESTAMP;
                                    res.value = acc_sh[23:0];
                                    acc_next  = '0;
                                end
                                else
                                begin
                                    acc_next = acc_sh;
                                end
                            end
                            else
                            begin
                                mod6_next = (mod6_reg == 3'd5) ? 3'd0 : mod6_reg + 3'd1;
                                if (boundary)
                                begin
                                    acc_next = '0;
                                    if (step_reg < eff_ranges)
                                    begin
                                        res_valid       = 1'b1;
                                        res.kind        = KIND_RANGE;
                                        res.step_index  = 11'(step_reg);
                                        res.value       = {6'd0, range_val};
                                        res.intensity   = intens;
                                        res.range_valid = (range_val >= MIN_RANGE_MM)
                                                          && (range_val <= cfg.max_range_mm);
                                        step_next       = step_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    acc_next = acc_sh;
                                end
                            end
                        end
                        pend_char_next = rx_char;
                        pend_flag_next = 1'b1;
                        prev_lf_next   = 1'b0;
                    end
                end
                default:
                begin
                    echo_ctrl.clear = 1'b1;
                    phase_next      = PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            pend_char_reg    <= '0;
            pend_flag_reg    <= 1'b0;
            prev_lf_reg      <= 1'b0;
            status_first_reg <= '0;
            count_reg        <= '0;
            mod6_reg         <= '0;
            acc_reg          <= '0;
            step_reg         <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pend_char_reg    <= pend_char_next;
            pend_flag_reg    <= pend_flag_next;
            prev_lf_reg      <= prev_lf_next;
            status_first_reg <= status_first_next;
            count_reg        <= count_next;
            mod6_reg         <= mod6_next;
            acc_reg          <= acc_next;
            step_reg         <= step_next;
        end
    end

    // a frame end always returns to the echo hunt
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        en && res_valid && res.kind == KIND_FRAME_END |=> phase_reg == PH_HUNT)
        else $error("frame end did not return to hunt");

    // results only come from the header LF check or the data lines
    a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> en && (phase_reg == PH_HDRLF || phase_reg == PH_DATA))
        else $error("result outside header or data phase");

    // leaving the hunt with an echo clears the frame counters
    a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && phase_reg == PH_HUNT && echo_ctrl.shift && echo_hit
        |=> count_reg == '0 && step_reg == '0 && phase_reg == PH_STATUS1)
        else $error("echo hit did not start a clean frame");

endmodule
